### rtl/core/tea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and helper functions for the TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int WORD_W = 32;
    localparam int KEY_WORDS = 4;
    localparam int CFG_INDEX_W = 2;

    typedef logic [WORD_W-1:0] word_t;

    // round constant
    localparam word_t TEA_DELTA = 32'h9e3779b9;

    // operation codes carried on tuser
    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 2'd3;

    // one block in flight
    typedef struct packed {
        op_t   op;
        word_t y;
        word_t z;
    } stage_t;

    // memory byte order <-> big-endian word order
    function automatic word_t bswap32(input word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // tea feistel mixing function
    function automatic word_t tea_mix(input word_t x, input word_t sum,
                                      input word_t ka, input word_t kb);
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage
`default_nettype wire

### rtl/core/tea_block_cipher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_block_cipher_unit
// Fully pipelined TEA encrypt/decrypt, one half-round per register stage.
// ----------------------------------------------------------------------------
// Usage:
//   - load the four key words through the cfg_wr_* port while no request is
//     in flight; each word is given in memory byte order
//   - a request on s_* carries one 64-bit block (two words, memory byte
//     order) and the operation on s_tuser (0 encrypt, 1 decrypt)
//   - the result block appears on m_* in memory byte order
// Throughput: one block per cycle while the skid register is empty; the
//   datapath is a chain of 2*ROUNDS half-round stages, each holding one
//   mix and one add/subtract.
// Path: a block passes the input register, the 2*ROUNDS half-round stages
//   and the output register from request acceptance to m_tvalid.
// Stall: when m_tready is low the output register holds; one more result
//   lands in a skid register, then s_tready drops and the whole pipeline
//   freezes until the skid register drains. Nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) clears all valid bits and the
//   key registers to zero.
// ----------------------------------------------------------------------------
module tea_block_cipher_unit #(
    parameter int ROUNDS = 32
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // configuration write port
    input  wire                            cfg_wr_en,
    input  wire [tea_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire [tea_pkg::WORD_W-1:0]      cfg_wr_data,
    // request channel
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [63:0]                     s_tdata,   // block_lo[31:0], block_hi[63:32]
    input  wire [0:0]                      s_tuser,   // op[0]
    // result channel
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [63:0]                    m_tdata    // out_lo[31:0], out_hi[63:32]
);
    import tea_pkg::*;

    localparam int STAGES = 2 * ROUNDS;

    // key registers
    word_t key_reg [KEY_WORDS];
    word_t key_sw  [KEY_WORDS];

    // pipeline registers: index 0 is the input register
    stage_t             pipe_reg  [STAGES+1];
    stage_t             pipe_next [STAGES];
    logic [STAGES:0]    valid_reg;

    // output and skid registers
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic               skid_valid_reg;
    logic [63:0]        skid_data_reg;

    logic               pipe_en;
    logic               out_free;
    logic               s_accept;
    logic [63:0]        last_data;

    // key register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_KEY_WORD0: key_reg[0] <= cfg_wr_data;
                REG_KEY_WORD1: key_reg[1] <= cfg_wr_data;
                REG_KEY_WORD2: key_reg[2] <= cfg_wr_data;
                REG_KEY_WORD3: key_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // keys in big-endian word order
    always_comb begin
        for (int i = 0; i < KEY_WORDS; i++) begin
            key_sw[i] = bswap32(key_reg[i]);
        end
    end

    // pipeline advances whenever the skid register is empty
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // half-round stages
    for (genvar h = 0; h < STAGES; h++) begin : g_half
        localparam int RND = h / 2;
        localparam bit SECOND = (h % 2) == 1;
        localparam logic [63:0] SUM_ENC64 = 64'(RND + 1) * 64'(TEA_DELTA);
        localparam logic [63:0] SUM_DEC64 = 64'(ROUNDS - RND) * 64'(TEA_DELTA);
        localparam word_t SUM_ENC = SUM_ENC64[WORD_W-1:0];
        localparam word_t SUM_DEC = SUM_DEC64[WORD_W-1:0];

        word_t mix_val;

        always_comb begin
            pipe_next[h] = pipe_reg[h];
            if (!SECOND) begin
                // encrypt updates y from z, decrypt updates z from y
                if (pipe_reg[h].op == OP_DECRYPT) begin
                    mix_val = tea_mix(pipe_reg[h].y, SUM_DEC, key_sw[2], key_sw[3]);
                    pipe_next[h].z = pipe_reg[h].z - mix_val;
                end else begin
                    mix_val = tea_mix(pipe_reg[h].z, SUM_ENC, key_sw[0], key_sw[1]);
                    pipe_next[h].y = pipe_reg[h].y + mix_val;
                end
            end else begin
                // encrypt updates z from y, decrypt updates y from z
                if (pipe_reg[h].op == OP_DECRYPT) begin
                    mix_val = tea_mix(pipe_reg[h].z, SUM_DEC, key_sw[0], key_sw[1]);
                    pipe_next[h].y = pipe_reg[h].y - mix_val;
                end else begin
                    mix_val = tea_mix(pipe_reg[h].y, SUM_ENC, key_sw[2], key_sw[3]);
                    pipe_next[h].z = pipe_reg[h].z + mix_val;
                end
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[STAGES-1:0], s_accept};
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pipe_reg[0].op <= op_t'(s_tuser[0]);
            pipe_reg[0].y  <= bswap32(s_tdata[31:0]);
            pipe_reg[0].z  <= bswap32(s_tdata[63:32]);
            for (int i = 0; i < STAGES; i++) begin
                pipe_reg[i+1] <= pipe_next[i];
            end
        end
    end

    // result in memory byte order
    assign last_data = {bswap32(pipe_reg[STAGES].z), bswap32(pipe_reg[STAGES].y)};

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg  <= skid_valid_reg || valid_reg[STAGES];
                skid_valid_reg <= 1'b0;
            end else if (pipe_en && valid_reg[STAGES]) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : last_data;
        end
        if (!out_free && pipe_en) begin
            skid_data_reg <= last_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

### rtl/core/tea_block_cipher_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_block_cipher_checker
// Port-level checks on the TEA block cipher unit, bound into every instance of it.
// ----------------------------------------------------------------------------
module tea_block_cipher_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [63:0] m_tdata
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // request side only backs off after an output stall
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready dropped without output stall");

    // a full skid register implies a pending result
    a_skid_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no pending result");

endmodule

bind tea_block_cipher_unit tea_block_cipher_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### bench/tea_block_cipher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_unit_test
// Self-checking bench for the pipelined TEA cipher. Directed blocks under
// edge-case keys are sent first. Random traffic follows under several keys,
// with random source gaps and sink stalls. Each result is checked against a
// cipher model kept in the bench, in request order.
// ----------------------------------------------------------------------------
module tea_block_cipher_unit_test;
    import tea_pkg::*;

    localparam int ROUNDS = 32;
    localparam int LATENCY = 2 * ROUNDS + 1;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_REQUESTS = 280;
    localparam int MAX_REPORTS = 50;

    // result words as they sit on m_tdata, lo in the low half
    typedef struct packed {
        word_t hi;
        word_t lo;
    } block_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = REG_KEY_WORD0;
    word_t                  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata = '0;   // block_lo[31:0], block_hi[63:32]
    logic [0:0]             s_tuser = '0;   // op[0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [63:0]            m_tdata;        // out_lo[31:0], out_hi[63:32]

    word_t       key_shadow [KEY_WORDS];
    block_t      pending_cipher_blocks [$];
    block_t      front_block;
    int unsigned mismatch_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned key_loads = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    bit          idling_on = 1'b0;

    always #4 aclk = ~aclk;

    tea_block_cipher_unit #(
        .ROUNDS(ROUNDS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // memory byte order to big-endian word order and back
    function automatic word_t swap_bytes(input word_t w);
        word_t r;
        int    i;
        for (i = 0; i < 4; i++) begin
            r[8*i +: 8] = w[8*(3-i) +: 8];
        end
        return r;
    endfunction

    // full tea encrypt or decrypt of one block under the current key
    function automatic block_t tea_cipher_block(input op_t op, input block_t blk);
        word_t  y;
        word_t  z;
        word_t  sum;
        word_t  k0;
        word_t  k1;
        word_t  k2;
        word_t  k3;
        block_t res;
        int     r;
        y  = swap_bytes(blk.lo);
        z  = swap_bytes(blk.hi);
        k0 = swap_bytes(key_shadow[0]);
        k1 = swap_bytes(key_shadow[1]);
        k2 = swap_bytes(key_shadow[2]);
        k3 = swap_bytes(key_shadow[3]);
        if (op == OP_ENCRYPT) begin
            sum = '0;
            for (r = 0; r < ROUNDS; r++) begin
                sum = sum + TEA_DELTA;
                y = y + (((z << 4) + k0) ^ (z + sum) ^ ((z >> 5) + k1));
                z = z + (((y << 4) + k2) ^ (y + sum) ^ ((y >> 5) + k3));
            end
        end else begin
            sum = TEA_DELTA * ROUNDS;
            for (r = 0; r < ROUNDS; r++) begin
                z = z - (((y << 4) + k2) ^ (y + sum) ^ ((y >> 5) + k3));
                y = y - (((z << 4) + k0) ^ (z + sum) ^ ((z >> 5) + k1));
                sum = sum - TEA_DELTA;
            end
        end
        res.lo = swap_bytes(y);
        res.hi = swap_bytes(z);
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idling_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
        end
        mismatch_count++;
    endtask

    // one request; entered and left at a falling edge
    task automatic send_block(input op_t op, input word_t lo, input word_t hi);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {hi, lo};
        do @(posedge aclk); while (!s_tready);
        pending_cipher_blocks.push_back(tea_cipher_block(op, {hi, lo}));
        requests_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_key_word(input logic [CFG_INDEX_W-1:0] idx, input word_t value);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        key_shadow[idx] = value;
    endtask

    // key changes only with the pipeline empty
    task automatic load_key(input word_t w0, input word_t w1, input word_t w2, input word_t w3);
        wait_drained();
        write_key_word(REG_KEY_WORD0, w0);
        write_key_word(REG_KEY_WORD1, w1);
        write_key_word(REG_KEY_WORD2, w2);
        write_key_word(REG_KEY_WORD3, w3);
        key_loads++;
    endtask

    task automatic wait_drained();
        while (pending_cipher_blocks.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // zero key from reset, edge-value blocks back to back
    task automatic test_reset_key_blocks();
        idling_on = 1'b0;
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_ENCRYPT, 32'h0000_00FF, 32'hFF00_0000);
        send_block(OP_ENCRYPT, 32'hDEAD_BEEF, 32'h0123_4567);
        send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // edge keys, byte order of the key, and encrypt/decrypt round trip
    task automatic test_edge_keys();
        block_t cipher;
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        cipher = tea_cipher_block(OP_ENCRYPT, {32'h7654_3210, 32'h89AB_CDEF});
        send_block(OP_ENCRYPT, 32'h89AB_CDEF, 32'h7654_3210);
        send_block(OP_DECRYPT, cipher.lo, cipher.hi);
        idling_on = 1'b1;
        load_key(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001);
        send_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_block(OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    endtask

    // random blocks under several keys, one phase without idling
    task automatic test_random_traffic();
        int     phase;
        int     n;
        op_t    op;
        word_t  lo;
        word_t  hi;
        block_t cipher;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    load_key('0, '0, '0, '0);
                end
                1: begin
                    load_key('1, '1, '1, '1);
                end
                default: begin
                    load_key($urandom, $urandom, $urandom, $urandom);
                end
            endcase
            idling_on = (phase != 2);
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                op = op_t'($urandom_range(0, 1));
                lo = $urandom;
                hi = $urandom;
                if ($urandom_range(0, 15) == 0) lo = $urandom_range(0, 1) ? '1 : '0;
                if ($urandom_range(0, 15) == 0) hi = $urandom_range(0, 1) ? '1 : '0;
                if ($urandom_range(0, 7) == 0) begin
                    // decrypt of a known ciphertext must give the plaintext back
                    cipher = tea_cipher_block(OP_ENCRYPT, {hi, lo});
                    send_block(OP_DECRYPT, cipher.lo, cipher.hi);
                end else begin
                    send_block(op, lo, hi);
                end
            end
        end
    endtask

    // sink side: random stalls on m_tready
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if (idling_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // result check against the oldest pending block
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cipher_blocks.size() == 0) begin
                report_mismatch("unrequested result", m_tdata[31:0], '0);
            end else begin
                front_block = pending_cipher_blocks.pop_front();
                if (m_tdata[31:0] !== front_block.lo) begin
                    report_mismatch("out_lo", m_tdata[31:0], front_block.lo);
                end
                if (m_tdata[63:32] !== front_block.hi) begin
                    report_mismatch("out_hi", m_tdata[63:32], front_block.hi);
                end
            end
            results_checked++;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // test sequence
    initial begin
        int k;
        for (k = 0; k < KEY_WORDS; k++) begin
            key_shadow[k] = '0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_key_blocks();
        test_edge_keys();
        test_random_traffic();
        wait_drained();
        repeat (LATENCY + 8) @(posedge aclk);
        $display("summary: %0d blocks sent, %0d results checked, %0d key loads",
                 requests_sent, results_checked, key_loads);
        $display("summary: zero, all-ones and random keys, both ops, gaps and stalls");
        if (mismatch_count == 0 && pending_cipher_blocks.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
